/* src/vpi_pkg.sv */
`default_nettype none
package vpi_pkg;

  localparam int POS_W       = 19;
  localparam int MOUSE_W     = 11;
  localparam int MDELTA_W    = 12;
  localparam int MODE_W      = 2;
  localparam int GRAV_W      = 8;
  localparam int FACT_W      = 9;
  localparam int RAD_W       = 16;
  localparam int AREA_W      = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int FACTOR_BITS = 8;

  localparam int FRAC_BITS_DEF = 8;

  localparam int POS_MAX = 262143;
  localparam int POS_MIN = -262144;

  localparam int MODE_DRAG    = 0;
  localparam int MODE_EXPLODE = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_FACTOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_FACTOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXPLODE_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT    = 3'd6;

  typedef struct packed {
    logic [GRAV_W-1:0] gravity;
    logic [FACT_W-1:0] drag_factor;
    logic [FACT_W-1:0] bounce_factor;
    logic [RAD_W-1:0]  drag_radius;
    logic [RAD_W-1:0]  explode_radius;
    logic [AREA_W-1:0] area_width;
    logic [AREA_W-1:0] area_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gravity:        8'd18,
    drag_factor:    9'd256,
    bounce_factor:  9'd77,
    drag_radius:    16'd7680,
    explode_radius: 16'd6400,
    area_width:     10'd800,
    area_height:    10'd600
  };

  // width of the previous position once the pointer has acted on it
  function automatic int prev_w(input int frac_bits);
    int msh;
    int dw;
    msh = MOUSE_W + frac_bits;
    dw  = ((POS_W > msh) ? POS_W : msh) + 1;
    return dw + 2;
  endfunction

endpackage
`default_nettype wire

/* src/vpi_cfg.sv */
`default_nettype none
module vpi_cfg
  import vpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_GRAVITY:        cfg.gravity        <= cfg_wdata[GRAV_W-1:0];
        REG_DRAG_FACTOR:    cfg.drag_factor    <= cfg_wdata[FACT_W-1:0];
        REG_BOUNCE_FACTOR:  cfg.bounce_factor  <= cfg_wdata[FACT_W-1:0];
        REG_DRAG_RADIUS:    cfg.drag_radius    <= cfg_wdata[RAD_W-1:0];
        REG_EXPLODE_RADIUS: cfg.explode_radius <= cfg_wdata[RAD_W-1:0];
        REG_AREA_WIDTH:     cfg.area_width     <= cfg_wdata[AREA_W-1:0];
        REG_AREA_HEIGHT:    cfg.area_height    <= cfg_wdata[AREA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/vpi_pointer.sv */
`default_nettype none
module vpi_pointer
  import vpi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [POS_W-1:0]             pos_x,
  input  logic signed [POS_W-1:0]             pos_y,
  input  logic signed [POS_W-1:0]             prev_x,
  input  logic signed [POS_W-1:0]             prev_y,
  input  logic                                pinned,
  input  logic signed [POS_W-1:0]             pin_x,
  input  logic signed [POS_W-1:0]             pin_y,
  input  logic signed [MOUSE_W-1:0]           mouse_x,
  input  logic signed [MOUSE_W-1:0]           mouse_y,
  input  logic signed [MDELTA_W-1:0]          mouse_dx,
  input  logic signed [MDELTA_W-1:0]          mouse_dy,
  input  logic [MODE_W-1:0]                   mouse_mode,
  input  cfg_t                                cfg,
  output logic                                pt_valid,
  input  logic                                pt_ready,
  output logic signed [POS_W-1:0]             pt_x,
  output logic signed [POS_W-1:0]             pt_y,
  output logic signed [prev_w(FRAC_BITS)-1:0] pt_ox,
  output logic signed [prev_w(FRAC_BITS)-1:0] pt_oy,
  output logic                                pt_pinned
);

  localparam int OW    = prev_w(FRAC_BITS);
  localparam int DW    = OW - 2;
  localparam int MSH_W = MOUSE_W + FRAC_BITS;
  localparam int SQ_W  = 2 * DW;
  localparam int D2_W  = 2 * DW;
  localparam int RSQ_W = 2 * RAD_W;

  logic v1, v2;
  logic en1, en2, en3;

  assign en3      = !pt_valid || pt_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // a pinned particle takes its pin position and skips the pointer
  logic signed [POS_W-1:0] x_in, y_in;
  logic [MODE_W-1:0]       mode_in;
  logic signed [MSH_W-1:0] mx_sh, my_sh, mdx_sh, mdy_sh;

  assign x_in    = pinned ? pin_x : pos_x;
  assign y_in    = pinned ? pin_y : pos_y;
  assign mode_in = pinned ? '0 : mouse_mode;
  assign mx_sh   = $signed({mouse_x, {FRAC_BITS{1'b0}}});
  assign my_sh   = $signed({mouse_y, {FRAC_BITS{1'b0}}});
  assign mdx_sh  = $signed({mouse_dx, {(FRAC_BITS-1){1'b0}}});
  assign mdy_sh  = $signed({mouse_dy, {(FRAC_BITS-1){1'b0}}});

  logic signed [POS_W-1:0] s1_x, s1_y, s1_ox, s1_oy;
  logic signed [DW-1:0]    s1_dx, s1_dy, s1_gx, s1_gy;
  logic [MODE_W-1:0]       s1_mode;
  logic                    s1_pinned;

  logic signed [SQ_W-1:0]  sqx_full, sqy_full;
  logic [SQ_W-2:0]         s2_sqx, s2_sqy;
  logic [RSQ_W-1:0]        s2_rd2, s2_re2;
  logic signed [OW-1:0]    s2_ex, s2_ey;
  logic signed [DW-1:0]    s2_gx, s2_gy;
  logic signed [POS_W-1:0] s2_x, s2_y, s2_ox, s2_oy;
  logic [MODE_W-1:0]       s2_mode;
  logic                    s2_pinned;

  logic [D2_W-1:0]         d2;
  logic                    hit_drag, hit_expl;
  logic signed [OW-1:0]    ox_next, oy_next;

  assign sqx_full = SQ_W'(s1_dx) * SQ_W'(s1_dx);
  assign sqy_full = SQ_W'(s1_dy) * SQ_W'(s1_dy);

  assign d2       = D2_W'(s2_sqx) + D2_W'(s2_sqy);
  assign hit_drag = s2_mode[MODE_DRAG] && (d2 < D2_W'(s2_rd2));
  assign hit_expl = s2_mode[MODE_EXPLODE] && (d2 < D2_W'(s2_re2));

  // explode overrides drag
  always_comb begin
    if (hit_expl) begin
      ox_next = s2_ex;
      oy_next = s2_ey;
    end else if (hit_drag) begin
      ox_next = OW'(s2_gx);
      oy_next = OW'(s2_gy);
    end else begin
      ox_next = OW'(s2_ox);
      oy_next = OW'(s2_oy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      pt_valid <= 1'b0;
    end else begin
      if (en1) v1       <= in_valid;
      if (en2) v2       <= v1;
      if (en3) pt_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_x      <= x_in;
      s1_y      <= y_in;
      s1_ox     <= prev_x;
      s1_oy     <= prev_y;
      s1_dx     <= DW'(x_in) - DW'(mx_sh);
      s1_dy     <= DW'(y_in) - DW'(my_sh);
      s1_gx     <= DW'(x_in) - DW'(mdx_sh);
      s1_gy     <= DW'(y_in) - DW'(mdy_sh);
      s1_mode   <= mode_in;
      s1_pinned <= pinned;
    end
    if (en2) begin
      s2_sqx    <= sqx_full[SQ_W-2:0];
      s2_sqy    <= sqy_full[SQ_W-2:0];
      s2_rd2    <= RSQ_W'(cfg.drag_radius) * RSQ_W'(cfg.drag_radius);
      s2_re2    <= RSQ_W'(cfg.explode_radius) * RSQ_W'(cfg.explode_radius);
      s2_ex     <= OW'(s1_x) - OW'(s1_dx) - OW'(s1_dx);
      s2_ey     <= OW'(s1_y) - OW'(s1_dy) - OW'(s1_dy);
      s2_gx     <= s1_gx;
      s2_gy     <= s1_gy;
      s2_x      <= s1_x;
      s2_y      <= s1_y;
      s2_ox     <= s1_ox;
      s2_oy     <= s1_oy;
      s2_mode   <= s1_mode;
      s2_pinned <= s1_pinned;
    end
    if (en3) begin
      pt_x      <= s2_x;
      pt_y      <= s2_y;
      pt_ox     <= ox_next;
      pt_oy     <= oy_next;
      pt_pinned <= s2_pinned;
    end
  end

endmodule
`default_nettype wire

/* src/vpi_motion.sv */
`default_nettype none
module vpi_motion
  import vpi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pt_valid,
  output logic                                pt_ready,
  input  logic signed [POS_W-1:0]             pt_x,
  input  logic signed [POS_W-1:0]             pt_y,
  input  logic signed [prev_w(FRAC_BITS)-1:0] pt_ox,
  input  logic signed [prev_w(FRAC_BITS)-1:0] pt_oy,
  input  logic                                pt_pinned,
  input  cfg_t                                cfg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [POS_W-1:0]             new_x,
  output logic signed [POS_W-1:0]             new_y,
  output logic signed [POS_W-1:0]             new_prev_x,
  output logic signed [POS_W-1:0]             new_prev_y
);

  localparam int OW   = prev_w(FRAC_BITS);
  localparam int DF_W = OW + 1;
  localparam int PR_W = DF_W + FACT_W + 1;
  localparam int VX_W = PR_W - FACTOR_BITS;
  localparam int NX_W = VX_W + 2;
  localparam int BP_W = VX_W + FACT_W + 1;
  localparam int BB_W = BP_W - FACTOR_BITS;
  localparam int WX_W = AREA_W + FRAC_BITS + 1;
  localparam int F_W  = ((NX_W > BB_W) ? NX_W : BB_W) + 1;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [F_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > F_W'(POS_MAX)) begin
      r = POS_W'(POS_MAX);
    end else if (v < F_W'(POS_MIN)) begin
      r = POS_W'(POS_MIN);
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  logic v1, v2, v3;
  logic en1, en2, en3, en4;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign pt_ready = en1;

  logic signed [FACT_W:0]   dfs, bfs;
  logic signed [GRAV_W:0]   grs;
  logic signed [WX_W-1:0]   wxs, hys;

  assign dfs = $signed({1'b0, cfg.drag_factor});
  assign bfs = $signed({1'b0, cfg.bounce_factor});
  assign grs = $signed({1'b0, cfg.gravity});
  assign wxs = $signed({1'b0, cfg.area_width, {FRAC_BITS{1'b0}}});
  assign hys = $signed({1'b0, cfg.area_height, {FRAC_BITS{1'b0}}});

  logic signed [DF_W-1:0]  m1_dx, m1_dy;
  logic signed [POS_W-1:0] m1_x, m1_y, m1_px, m1_py;
  logic                    m1_pinned;

  logic signed [PR_W-1:0]  prod_x, prod_y;
  logic signed [VX_W-1:0]  m2_vx, m2_vy;
  logic signed [POS_W-1:0] m2_x, m2_y, m2_px, m2_py;
  logic                    m2_pinned;

  logic signed [NX_W-1:0]  nx, ny;
  logic signed [BP_W-1:0]  bp_x, bp_y;
  logic signed [NX_W-1:0]  m3_nx, m3_ny;
  logic signed [BB_W-1:0]  m3_bx, m3_by;
  logic                    m3_hx, m3_lx, m3_hy, m3_ly;
  logic signed [POS_W-1:0] m3_x, m3_y, m3_px, m3_py;
  logic                    m3_pinned;

  logic signed [F_W-1:0]   fx, fy, fox, foy;

  assign prod_x = PR_W'(m1_dx) * PR_W'(dfs);
  assign prod_y = PR_W'(m1_dy) * PR_W'(dfs);

  assign nx   = NX_W'(m2_x) + NX_W'(m2_vx);
  assign ny   = NX_W'(m2_y) + NX_W'(m2_vy) + NX_W'(grs);
  assign bp_x = BP_W'(m2_vx) * BP_W'(bfs);
  assign bp_y = BP_W'(m2_vy) * BP_W'(bfs);

  // clamp to the area edge and reflect the velocity
  always_comb begin
    if (m3_hx) begin
      fx  = F_W'(wxs);
      fox = F_W'(wxs) + F_W'(m3_bx);
    end else if (m3_lx) begin
      fx  = F_W'(0);
      fox = F_W'(m3_bx);
    end else begin
      fx  = F_W'(m3_nx);
      fox = F_W'(m3_x);
    end
    if (m3_hy) begin
      fy  = F_W'(hys);
      foy = F_W'(hys) + F_W'(m3_by);
    end else if (m3_ly) begin
      fy  = F_W'(0);
      foy = F_W'(m3_by);
    end else begin
      fy  = F_W'(m3_ny);
      foy = F_W'(m3_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1        <= pt_valid;
      if (en2) v2        <= v1;
      if (en3) v3        <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      m1_dx     <= DF_W'(pt_x) - DF_W'(pt_ox);
      m1_dy     <= DF_W'(pt_y) - DF_W'(pt_oy);
      m1_x      <= pt_x;
      m1_y      <= pt_y;
      m1_px     <= pt_ox[POS_W-1:0];
      m1_py     <= pt_oy[POS_W-1:0];
      m1_pinned <= pt_pinned;
    end
    if (en2) begin
      m2_vx     <= VX_W'(prod_x >>> FACTOR_BITS);
      m2_vy     <= VX_W'(prod_y >>> FACTOR_BITS);
      m2_x      <= m1_x;
      m2_y      <= m1_y;
      m2_px     <= m1_px;
      m2_py     <= m1_py;
      m2_pinned <= m1_pinned;
    end
    if (en3) begin
      m3_nx     <= nx;
      m3_ny     <= ny;
      m3_hx     <= nx > NX_W'(wxs);
      m3_lx     <= nx[NX_W-1];
      m3_hy     <= ny > NX_W'(hys);
      m3_ly     <= ny[NX_W-1];
      m3_bx     <= BB_W'(bp_x >>> FACTOR_BITS);
      m3_by     <= BB_W'(bp_y >>> FACTOR_BITS);
      m3_x      <= m2_x;
      m3_y      <= m2_y;
      m3_px     <= m2_px;
      m3_py     <= m2_py;
      m3_pinned <= m2_pinned;
    end
    if (en4) begin
      new_x      <= m3_pinned ? m3_x  : sat_pos(fx);
      new_y      <= m3_pinned ? m3_y  : sat_pos(fy);
      new_prev_x <= m3_pinned ? m3_px : sat_pos(fox);
      new_prev_y <= m3_pinned ? m3_py : sat_pos(foy);
    end
  end

endmodule
`default_nettype wire

/* src/verlet_point_integrate_core.sv */
// Verlet step for one cloth particle per request.
//
// Requests enter on in_valid/in_ready with the particle, its pin and the
// pointer state; results leave on out_valid/out_ready as the new position and
// new previous position, saturated to 19 bits. Settings are written through
// cfg_write/cfg_addr/cfg_wdata; the user must do so only while no request is
// in flight (not enforced by the block). An unknown index is ignored.
//
// Pipeline: seven register stages from request to output (three for the
// pointer test, four for damping, gravity and edge bounce). Throughput: one
// request per cycle while out_ready is not held low.
//
// A stall on out_ready holds the output register; bubbles in the pipe still
// close up, so in_ready drops only once every stage holds a request.
// Reset empties the pipe and loads the default settings.
`default_nettype none
module verlet_point_integrate_core
  import vpi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] prev_x,
  input  logic signed [POS_W-1:0] prev_y,
  input  logic                    pinned,
  input  logic signed [POS_W-1:0] pin_x,
  input  logic signed [POS_W-1:0] pin_y,
  input  logic signed [MOUSE_W-1:0]  mouse_x,
  input  logic signed [MOUSE_W-1:0]  mouse_y,
  input  logic signed [MDELTA_W-1:0] mouse_dx,
  input  logic signed [MDELTA_W-1:0] mouse_dy,
  input  logic [MODE_W-1:0]       mouse_mode,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] new_x,
  output logic signed [POS_W-1:0] new_y,
  output logic signed [POS_W-1:0] new_prev_x,
  output logic signed [POS_W-1:0] new_prev_y
);

  localparam int OW = prev_w(FRAC_BITS);

  cfg_t                    cfg;
  logic                    pt_valid, pt_ready, pt_pinned;
  logic signed [POS_W-1:0] pt_x, pt_y;
  logic signed [OW-1:0]    pt_ox, pt_oy;

  vpi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vpi_pointer #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pointer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .prev_x     (prev_x),
    .prev_y     (prev_y),
    .pinned     (pinned),
    .pin_x      (pin_x),
    .pin_y      (pin_y),
    .mouse_x    (mouse_x),
    .mouse_y    (mouse_y),
    .mouse_dx   (mouse_dx),
    .mouse_dy   (mouse_dy),
    .mouse_mode (mouse_mode),
    .cfg        (cfg),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pt_x       (pt_x),
    .pt_y       (pt_y),
    .pt_ox      (pt_ox),
    .pt_oy      (pt_oy),
    .pt_pinned  (pt_pinned)
  );

  vpi_motion #(
    .FRAC_BITS (FRAC_BITS)
  ) u_motion (
    .clk        (clk),
    .rst        (rst),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pt_x       (pt_x),
    .pt_y       (pt_y),
    .pt_ox      (pt_ox),
    .pt_oy      (pt_oy),
    .pt_pinned  (pt_pinned),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .new_x      (new_x),
    .new_y      (new_y),
    .new_prev_x (new_prev_x),
    .new_prev_y (new_prev_y)
  );

endmodule
`default_nettype wire

/* src/vpi_checker.sv */
`default_nettype none
module vpi_checker
  import vpi_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] new_x,
  input logic signed [POS_W-1:0] new_y,
  input logic signed [POS_W-1:0] new_prev_x,
  input logic signed [POS_W-1:0] new_prev_y
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("request refused while the output is not stalled");

  a_idle_input_no_stall: assert property (@(posedge clk) disable iff (rst)
    (out_ready && !in_valid) |-> in_ready)
    else $error("request port blocked with a free output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(new_x) && $stable(new_y)
      && $stable(new_prev_x) && $stable(new_prev_y)))
    else $error("stalled result changed or dropped");

endmodule

bind verlet_point_integrate_core vpi_checker u_vpi_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .new_x      (new_x),
  .new_y      (new_y),
  .new_prev_x (new_prev_x),
  .new_prev_y (new_prev_y)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import vpi_pkg::*;

  localparam int PIX = 1 << FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FRAC_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [MODE_W-1:0] PTR_NONE    = 2'b00;
  localparam logic [MODE_W-1:0] PTR_DRAG    = 2'b01;
  localparam logic [MODE_W-1:0] PTR_EXPLODE = 2'b10;
  localparam logic [MODE_W-1:0] PTR_BOTH    = 2'b11;

  typedef struct packed {
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic signed [POS_W-1:0]    prev_x;
    logic signed [POS_W-1:0]    prev_y;
    logic                       pinned;
    logic signed [POS_W-1:0]    pin_x;
    logic signed [POS_W-1:0]    pin_y;
    logic signed [MOUSE_W-1:0]  mouse_x;
    logic signed [MOUSE_W-1:0]  mouse_y;
    logic signed [MDELTA_W-1:0] mouse_dx;
    logic signed [MDELTA_W-1:0] mouse_dy;
    logic [MODE_W-1:0]          mouse_mode;
  } particle_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [POS_W-1:0] new_prev_x;
    logic signed [POS_W-1:0] new_prev_y;
  } particle_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic signed [POS_W-1:0] prev_x = '0;
  logic signed [POS_W-1:0] prev_y = '0;
  logic pinned = 1'b0;
  logic signed [POS_W-1:0] pin_x = '0;
  logic signed [POS_W-1:0] pin_y = '0;
  logic signed [MOUSE_W-1:0] mouse_x = '0;
  logic signed [MOUSE_W-1:0] mouse_y = '0;
  logic signed [MDELTA_W-1:0] mouse_dx = '0;
  logic signed [MDELTA_W-1:0] mouse_dy = '0;
  logic [MODE_W-1:0] mouse_mode = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic signed [POS_W-1:0] new_prev_x;
  logic signed [POS_W-1:0] new_prev_y;

  cfg_t cfg_model = CFG_RESET;
  particle_out_t expected_positions[$];
  int mismatches = 0;
  int in_gap_pct = 35;
  int out_stall_pct = 35;
  int rx_hold_left = 0;

  verlet_point_integrate_core dut (.*);

  always #5 clk = ~clk;

  initial begin : watchdog
    #5_000_000;
    $display("verlet_point_integrate_core test failed");
    $finish;
  end

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return POS_W'(v);
  endfunction

  function automatic logic signed [POS_W-1:0] fit_pos(input int v);
    return clamp_pos(longint'(v));
  endfunction

  function automatic logic signed [MOUSE_W-1:0] fit_mouse(input int v);
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    return MOUSE_W'(v);
  endfunction

  function automatic particle_out_t integrate_particle(input particle_in_t p, input cfg_t c);
    longint x, y, ox, oy, dx, dy, d2, rd, re, vx, vy, nx, ny, nox, noy, wx, hy;
    particle_out_t o;
    x = p.pos_x;
    y = p.pos_y;
    ox = p.prev_x;
    oy = p.prev_y;
    if (p.pinned) begin
      o.new_x = p.pin_x;
      o.new_y = p.pin_y;
      o.new_prev_x = p.prev_x;
      o.new_prev_y = p.prev_y;
      return o;
    end
    if (p.mouse_mode != PTR_NONE) begin
      dx = x - longint'(p.mouse_x) * ONE;
      dy = y - longint'(p.mouse_y) * ONE;
      d2 = dx * dx + dy * dy;
      rd = longint'(c.drag_radius);
      re = longint'(c.explode_radius);
      if (p.mouse_mode[MODE_DRAG] && d2 < rd * rd) begin
        ox = x - longint'(p.mouse_dx) * (ONE / 2);
        oy = y - longint'(p.mouse_dy) * (ONE / 2);
      end
      if (p.mouse_mode[MODE_EXPLODE] && d2 < re * re) begin
        ox = x - 2 * dx;
        oy = y - 2 * dy;
      end
    end
    vx = ((x - ox) * longint'(c.drag_factor)) >>> FACTOR_BITS;
    vy = ((y - oy) * longint'(c.drag_factor)) >>> FACTOR_BITS;
    nox = x;
    noy = y;
    nx = x + vx;
    ny = y + vy + longint'(c.gravity);
    wx = longint'(c.area_width) * ONE;
    hy = longint'(c.area_height) * ONE;
    if (nx > wx) begin
      nx = wx;
      nox = nx + ((vx * longint'(c.bounce_factor)) >>> FACTOR_BITS);
    end else if (nx < 0) begin
      nx = 0;
      nox = (vx * longint'(c.bounce_factor)) >>> FACTOR_BITS;
    end
    if (ny > hy) begin
      ny = hy;
      noy = ny + ((vy * longint'(c.bounce_factor)) >>> FACTOR_BITS);
    end else if (ny < 0) begin
      ny = 0;
      noy = (vy * longint'(c.bounce_factor)) >>> FACTOR_BITS;
    end
    o.new_x = clamp_pos(nx);
    o.new_y = clamp_pos(ny);
    o.new_prev_x = clamp_pos(nox);
    o.new_prev_y = clamp_pos(noy);
    return o;
  endfunction

  function automatic particle_in_t still_particle(input int x, input int y);
    particle_in_t p;
    p = '0;
    p.pos_x = fit_pos(x);
    p.pos_y = fit_pos(y);
    p.prev_x = p.pos_x;
    p.prev_y = p.pos_y;
    return p;
  endfunction

  function automatic particle_in_t with_pointer(input particle_in_t p, input int mx, input int my,
                                                input int mdx, input int mdy,
                                                input logic [MODE_W-1:0] mode);
    p.mouse_x = fit_mouse(mx);
    p.mouse_y = fit_mouse(my);
    p.mouse_dx = MDELTA_W'(mdx);
    p.mouse_dy = MDELTA_W'(mdy);
    p.mouse_mode = mode;
    return p;
  endfunction

  function automatic particle_in_t random_particle();
    particle_in_t p;
    int px, py;
    p.pinned = ($urandom_range(99) < 10);
    p.pin_x = POS_W'($urandom());
    p.pin_y = POS_W'($urandom());
    p.mouse_dx = MDELTA_W'($urandom());
    p.mouse_dy = MDELTA_W'($urandom());
    p.mouse_mode = MODE_W'($urandom());
    if ($urandom_range(99) < 20) begin
      p.pos_x = POS_W'($urandom());
      p.pos_y = POS_W'($urandom());
      p.prev_x = POS_W'($urandom());
      p.prev_y = POS_W'($urandom());
      p.mouse_x = MOUSE_W'($urandom());
      p.mouse_y = MOUSE_W'($urandom());
    end else begin
      px = int'($urandom_range(0, cfg_model.area_width * PIX + 4096)) - 2048;
      py = int'($urandom_range(0, cfg_model.area_height * PIX + 4096)) - 2048;
      p.pos_x = fit_pos(px);
      p.pos_y = fit_pos(py);
      p.prev_x = fit_pos(px + int'($urandom_range(0, 6000)) - 3000);
      p.prev_y = fit_pos(py + int'($urandom_range(0, 6000)) - 3000);
      p.mouse_x = fit_mouse((px >>> FRAC_BITS_DEF) + int'($urandom_range(0, 80)) - 40);
      p.mouse_y = fit_mouse((py >>> FRAC_BITS_DEF) + int'($urandom_range(0, 80)) - 40);
    end
    return p;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.gravity = GRAV_W'($urandom());
    c.drag_factor = ($urandom_range(9) == 0) ? FACT_W'($urandom()) : FACT_W'($urandom_range(256));
    c.bounce_factor = ($urandom_range(9) == 0) ? FACT_W'($urandom())
                                               : FACT_W'($urandom_range(256));
    c.drag_radius = ($urandom_range(9) == 0) ? RAD_W'($urandom()) : RAD_W'($urandom_range(20000));
    c.explode_radius = ($urandom_range(9) == 0) ? RAD_W'($urandom())
                                                : RAD_W'($urandom_range(20000));
    c.area_width = AREA_W'($urandom_range(1, 1023));
    c.area_height = AREA_W'($urandom_range(1, 1023));
    return c;
  endfunction

  // set the bits above the register width to noise
  function automatic logic [CFG_DATA_W-1:0] noisy(input logic [CFG_DATA_W-1:0] v, input int w);
    logic [CFG_DATA_W-1:0] keep;
    keep = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
    return (CFG_DATA_W'($urandom()) & ~keep) | (v & keep);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic signed [POS_W-1:0] got,
                             input logic signed [POS_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c, input bit junk);
    write_reg(REG_GRAVITY, noisy(CFG_DATA_W'(c.gravity), GRAV_W));
    write_reg(REG_DRAG_FACTOR, noisy(CFG_DATA_W'(c.drag_factor), FACT_W));
    write_reg(REG_BOUNCE_FACTOR, noisy(CFG_DATA_W'(c.bounce_factor), FACT_W));
    write_reg(REG_DRAG_RADIUS, noisy(CFG_DATA_W'(c.drag_radius), RAD_W));
    write_reg(REG_EXPLODE_RADIUS, noisy(CFG_DATA_W'(c.explode_radius), RAD_W));
    write_reg(REG_AREA_WIDTH, noisy(CFG_DATA_W'(c.area_width), AREA_W));
    write_reg(REG_AREA_HEIGHT, noisy(CFG_DATA_W'(c.area_height), AREA_W));
    if (junk) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_write <= 1'b0;
    cfg_model = c;
  endtask

  task automatic push_particle(input particle_in_t p);
    while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= p.pos_x;
    pos_y <= p.pos_y;
    prev_x <= p.prev_x;
    prev_y <= p.prev_y;
    pinned <= p.pinned;
    pin_x <= p.pin_x;
    pin_y <= p.pin_y;
    mouse_x <= p.mouse_x;
    mouse_y <= p.mouse_y;
    mouse_dx <= p.mouse_dx;
    mouse_dy <= p.mouse_dy;
    mouse_mode <= p.mouse_mode;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_positions.push_back(integrate_particle(p, cfg_model));
  endtask

  // drop valid and drain the pipe
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin : result_monitor
    particle_out_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d", new_x, new_y));
        end else begin
          want = expected_positions.pop_front();
          check_field("new_x", new_x, want.new_x);
          check_field("new_y", new_y, want.new_y);
          check_field("new_prev_x", new_prev_x, want.new_prev_x);
          check_field("new_prev_y", new_prev_y, want.new_prev_y);
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left = rx_hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(out_stall_pct != 0 && $urandom_range(99) < out_stall_pct);
      end
    end
  end

  task automatic test_directed_motion();
    particle_in_t p;
    p = still_particle(0, 0);
    p.pinned = 1'b1;
    p.pin_x = fit_pos(POS_MAX);
    p.pin_y = fit_pos(POS_MIN);
    p.prev_x = fit_pos(POS_MIN);
    p.prev_y = fit_pos(POS_MAX);
    push_particle(p);
    p = with_pointer(still_particle(105 * PIX, 100 * PIX), 100, 100, 2047, -2048, PTR_BOTH);
    p.pinned = 1'b1;
    p.pin_x = fit_pos(POS_MIN);
    p.pin_y = fit_pos(POS_MAX);
    p.prev_x = fit_pos(POS_MAX);
    p.prev_y = fit_pos(POS_MIN);
    push_particle(p);
    push_particle(still_particle(100 * PIX, 100 * PIX));
    p = still_particle(799 * PIX, 300 * PIX);
    p.prev_x = fit_pos(790 * PIX);
    push_particle(p);
    p = still_particle(2 * PIX, 300 * PIX);
    p.prev_x = fit_pos(10 * PIX);
    push_particle(p);
    p = still_particle(300 * PIX, 599 * PIX);
    p.prev_y = fit_pos(590 * PIX);
    push_particle(p);
    p = still_particle(300 * PIX, PIX);
    p.prev_y = fit_pos(1000);
    push_particle(p);
    push_particle(with_pointer(still_particle(110 * PIX, 100 * PIX), 100, 100, 2047, -2048,
                               PTR_DRAG));
    push_particle(with_pointer(still_particle(130 * PIX, 100 * PIX), 100, 100, 50, 50,
                               PTR_DRAG));
    push_particle(with_pointer(still_particle(130 * PIX - 1, 100 * PIX), 100, 100, 50, 50,
                               PTR_DRAG));
    push_particle(with_pointer(still_particle(105 * PIX, 103 * PIX), 100, 100, 9, 9,
                               PTR_EXPLODE));
    push_particle(with_pointer(still_particle(125 * PIX, 100 * PIX), 100, 100, 9, 9,
                               PTR_EXPLODE));
    push_particle(with_pointer(still_particle(105 * PIX, 100 * PIX), 100, 100, -2048, 2047,
                               PTR_BOTH));
    push_particle(with_pointer(still_particle(127 * PIX, 100 * PIX), 100, 100, -7, 13,
                               PTR_BOTH));
    push_particle(with_pointer(still_particle(POS_MIN, POS_MIN), -1024, -1024, -2048, -2048,
                               PTR_BOTH));
    push_particle(with_pointer(still_particle(POS_MAX, POS_MAX), 1023, 1023, 2047, 2047,
                               PTR_BOTH));
    p = still_particle(POS_MAX, POS_MAX);
    p.prev_x = fit_pos(POS_MIN);
    p.prev_y = fit_pos(POS_MIN);
    push_particle(p);
    p = still_particle(POS_MIN, POS_MIN);
    p.prev_x = fit_pos(POS_MAX);
    p.prev_y = fit_pos(POS_MAX);
    push_particle(p);
    push_particle(still_particle(0, 0));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    particle_in_t p;
    c = '{gravity: 8'd255, drag_factor: 9'd511, bounce_factor: 9'd511,
          drag_radius: 16'hFFFF, explode_radius: 16'hFFFF,
          area_width: 10'd1023, area_height: 10'd1023};
    load_settings(c, 1'b0);
    p = still_particle(1022 * PIX, 1022 * PIX);
    p.prev_x = fit_pos(1000 * PIX);
    p.prev_y = fit_pos(1000 * PIX);
    push_particle(p);
    repeat (20) push_particle(random_particle());
    wait_idle();
    load_settings('0, 1'b1);
    push_particle(still_particle(0, 0));
    p = still_particle(PIX, PIX);
    p.prev_x = fit_pos(2 * PIX);
    p.prev_y = fit_pos(2 * PIX);
    push_particle(p);
    repeat (20) push_particle(random_particle());
    wait_idle();
    c = '{gravity: 8'd255, drag_factor: 9'd256, bounce_factor: 9'd256,
          drag_radius: 16'd0, explode_radius: 16'hFFFF,
          area_width: 10'd1, area_height: 10'd1};
    load_settings(c, 1'b1);
    repeat (20) push_particle(random_particle());
    wait_idle();
  endtask

  task automatic test_random_settings();
    int ph;
    for (ph = 0; ph < 6; ph++) begin
      in_gap_pct = (ph == 2) ? 0 : 35;
      out_stall_pct = (ph == 2) ? 0 : 35;
      load_settings(random_cfg(), ph[0]);
      repeat (80) push_particle(random_particle());
      wait_idle();
    end
    in_gap_pct = 35;
    out_stall_pct = 35;
  endtask

  task automatic test_output_backpressure();
    in_gap_pct = 0;
    rx_hold_left = 120;
    repeat (40) push_particle(random_particle());
    in_gap_pct = 35;
    wait_idle();
  endtask

  task automatic test_sender_pause();
    repeat (30) push_particle(random_particle());
    wait_idle();
    repeat (30) push_particle(random_particle());
    wait_idle();
  endtask

  initial begin : run
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_motion();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();
    wait_idle();
    if (mismatches == 0) begin
      $display("verlet_point_integrate_core test passed");
    end else begin
      $display("verlet_point_integrate_core test failed");
    end
    $finish;
  end

endmodule
